@@ src/bcd_add_subtract_top_macros.svh @@
// assertion macros shared by the bcd add/subtract checker
`ifndef BCD_ADD_SUBTRACT_TOP_MACROS_SVH
`define BCD_ADD_SUBTRACT_TOP_MACROS_SVH

// implication check, antecedent and consequent given as sequences
`define BCD_AS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bcd_as check failed");

// plain invariant outside reset
`define BCD_AS_ASSERT_ALWAYS(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("bcd_as check failed");

`endif

@@ src/bcd_as_pkg.sv @@
// package with widths, status codes and the stage record of the bcd chain
package bcd_as_pkg;

  localparam int DATA_W       = 64;
  localparam int DIGIT_W      = 4;
  localparam int CNT_W        = 5;
  localparam int TOTAL_DIGITS = 16;
  localparam int MAX_DIGITS   = 16;
  localparam logic [CNT_W-1:0] DIGITS_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // data that travels from one digit cell to the next
  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] res;
    logic              carry;
    logic              bad;
  } stage_t;

endpackage

@@ src/bcd_as_cell.sv @@
// one digit cell: checks and adds or subtracts a single bcd digit, registered
module bcd_as_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_in,
  input  bcd_as_pkg::stage_t           stage_in,
  input  logic [bcd_as_pkg::CNT_W-1:0] n,
  output logic                         valid_out,
  output bcd_as_pkg::stage_t           stage_out
);

  localparam int LSB = IDX * bcd_as_pkg::DIGIT_W;
  localparam logic [bcd_as_pkg::CNT_W-1:0] IDX_N = bcd_as_pkg::CNT_W'(IDX);

  logic               in_use;
  logic [3:0]         da;
  logic [3:0]         db;
  logic [4:0]         sum;
  logic [4:0]         sub;
  logic               c_add;
  logic               c_sub;
  logic [3:0]         d_add;
  logic [3:0]         d_sub;
  bcd_as_pkg::stage_t stage_next;

  assign in_use = IDX_N < n;
  assign da     = stage_in.a[LSB +: 4];
  assign db     = stage_in.b[LSB +: 4];

  // decimal add digit
  assign sum   = {1'b0, da} + {1'b0, db} + {4'b0, stage_in.carry};
  assign c_add = sum >= 5'd10;
  assign d_add = c_add ? 4'(sum - 5'd10) : sum[3:0];

  // decimal subtract digit with borrow
  assign sub   = {1'b0, db} + {4'b0, stage_in.carry};
  assign c_sub = {1'b0, da} < sub;
  assign d_sub = c_sub ? 4'({1'b0, da} + 5'd10 - sub) : 4'({1'b0, da} - sub);

  // update this digit when in use, otherwise pass through
  always_comb begin
    stage_next = stage_in;
    if (in_use) begin
      stage_next.bad = stage_in.bad | (da > 4'd9) | (db > 4'd9);
      if (stage_in.cmd) begin
        stage_next.carry         = c_sub;
        stage_next.res[LSB +: 4] = d_sub;
      end else begin
        stage_next.carry         = c_add;
        stage_next.res[LSB +: 4] = d_add;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    stage_out <= stage_next;
  end

endmodule

@@ src/bcd_add_subtract_top.sv @@
// top level of the packed bcd adder/subtractor, a chain of digit cells
//
// One transaction is accepted in every cycle (busy is only high in reset).
// Each transaction walks a chain of MAX_DIGITS digit cells, one digit per
// cell per cycle, then an output register, so its result appears on result
// and status with done high once it has passed every cell and the output
// register, in acceptance order. Results are not held: the receiver must take each one
// in its done cycle. Digits at or above digits_in_use (saturated to
// MAX_DIGITS) pass through from operand_a. digits_in_use is written over the
// cfg port (cfg_ready is always high) and should only change while the chain
// is empty.
module bcd_add_subtract_top #(
  parameter int MAX_DIGITS = bcd_as_pkg::MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [bcd_as_pkg::DATA_W-1:0] operand_a,
  input  logic [bcd_as_pkg::DATA_W-1:0] operand_b,
  output logic                          done,
  output logic [bcd_as_pkg::DATA_W-1:0] result,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcd_as_pkg::CNT_W-1:0]  cfg_data
);

  localparam logic [bcd_as_pkg::CNT_W-1:0] MAX_N = bcd_as_pkg::CNT_W'(MAX_DIGITS);

  logic [bcd_as_pkg::CNT_W-1:0] digits_in_use;
  logic [bcd_as_pkg::CNT_W-1:0] n_sat;
  logic                         vld   [0:MAX_DIGITS];
  bcd_as_pkg::stage_t           stage [0:MAX_DIGITS];
  bcd_as_pkg::status_t          status_next;
  logic [bcd_as_pkg::DATA_W-1:0] result_next;
  bcd_as_pkg::status_t          status_reg;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      digits_in_use <= bcd_as_pkg::DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      digits_in_use <= cfg_data;
    end
  end

  assign n_sat = (digits_in_use > MAX_N) ? MAX_N : digits_in_use;

  // chain entry
  assign vld[0]         = start && !busy;
  assign stage[0].cmd   = command;
  assign stage[0].a     = operand_a;
  assign stage[0].b     = operand_b;
  assign stage[0].res   = operand_a;
  assign stage[0].carry = 1'b0;
  assign stage[0].bad   = 1'b0;

  // row of digit cells
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    bcd_as_cell #(.IDX(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[k]),
      .stage_in  (stage[k]),
      .n         (n_sat),
      .valid_out (vld[k+1]),
      .stage_out (stage[k+1])
    );
  end

  // final status selection, bad digit before overflow
  always_comb begin
    priority if (stage[MAX_DIGITS].bad) begin
      status_next = bcd_as_pkg::ST_BAD_DIGIT;
      result_next = stage[MAX_DIGITS].a;
    end else if (stage[MAX_DIGITS].carry) begin
      status_next = bcd_as_pkg::ST_OVERFLOW;
      result_next = stage[MAX_DIGITS].a;
    end else begin
      status_next = bcd_as_pkg::ST_OK;
      result_next = stage[MAX_DIGITS].res;
    end
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[MAX_DIGITS];
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    result     <= result_next;
    status_reg <= status_next;
  end

  assign status = status_reg;

endmodule

@@ src/bcd_as_checker.sv @@
// port level checker for the bcd adder/subtractor, bound to the top level
`include "bcd_add_subtract_top_macros.svh"

module bcd_as_checker #(
  parameter int MAX_DIGITS = bcd_as_pkg::MAX_DIGITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          command,
  input logic [bcd_as_pkg::DATA_W-1:0] operand_a,
  input logic [bcd_as_pkg::DATA_W-1:0] operand_b,
  input logic                          done,
  input logic [bcd_as_pkg::DATA_W-1:0] result,
  input logic [1:0]                    status,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [bcd_as_pkg::CNT_W-1:0]  cfg_data
);

  localparam int LAT = MAX_DIGITS + 1;

  // every accepted transaction leads to a done strobe once it has left the chain
  `BCD_AS_ASSERT_IMP(a_done_follows, clk, rst, start && !busy, ##LAT done)

  // no result without an earlier accepted transaction to match it
  `BCD_AS_ASSERT_IMP(a_no_invent, clk, rst, done, $past(start && !busy, LAT))

  // an error status hands back operand a unchanged
  `BCD_AS_ASSERT_IMP(a_err_keeps_a, clk, rst,
    done && (status != 2'd0), result == $past(operand_a, LAT))

  // the unused status code never shows
  `BCD_AS_ASSERT_ALWAYS(a_status_code, clk, rst, !(done && (status == 2'd3)))

endmodule

bind bcd_add_subtract_top bcd_as_checker #(.MAX_DIGITS(MAX_DIGITS)) u_bcd_as_checker (.*);

@@ sim/tb_bcd_add_subtract_top.sv @@
// testbench for the packed bcd adder/subtractor top level
`timescale 1ns / 100ps

module tb_bcd_add_subtract_top;

  localparam int DATA_W      = bcd_as_pkg::DATA_W;
  localparam int CNT_W       = bcd_as_pkg::CNT_W;
  localparam int MAX_DIGITS  = bcd_as_pkg::MAX_DIGITS;
  localparam logic [CNT_W-1:0] DIGITS_RESET = bcd_as_pkg::DIGITS_RESET;
  localparam int CLK_HALF    = 2;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = MAX_DIGITS + 8;
  localparam int PRINT_CAP   = 50;

  // expected outcome of one operation, with its operands for messages
  typedef struct {
    logic                logic_pad;
    logic                cmd;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
    logic [DATA_W-1:0]   value;
    bcd_as_pkg::status_t code;
  } bcd_outcome_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              command;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  logic              done;
  logic [DATA_W-1:0] result;
  logic [1:0]        status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;

  bcd_outcome_t      pending_sums[$];
  logic [CNT_W-1:0]  digits_cfg;
  int                idle_pct;
  int                error_count;
  int                n_ops;
  int                n_ok;
  int                n_bad;
  int                n_ovf;
  int                n_cfg;

  bcd_add_subtract_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .result    (result),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // free-running clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // digit count after saturation
  function automatic int used_digits(input logic [CNT_W-1:0] digits);
    return (int'(digits) > MAX_DIGITS) ? MAX_DIGITS : int'(digits);
  endfunction

  // decimal add/subtract over the low digits, a passes through on error
  function automatic bcd_outcome_t predict_bcd(input logic cmd, input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b,
                                               input logic [CNT_W-1:0] digits);
    bcd_outcome_t      o;
    int                n;
    int                i;
    int                da;
    int                db;
    int                d;
    logic              carry;
    logic              bad;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] keep;
    o.logic_pad = 1'b0;
    o.cmd = cmd;
    o.a   = a;
    o.b   = b;
    n     = used_digits(digits);
    bad   = 1'b0;
    carry = 1'b0;
    low   = '0;
    for (i = 0; i < n; i++) begin
      if (a[4*i +: 4] > 4'd9 || b[4*i +: 4] > 4'd9) bad = 1'b1;
    end
    if (bad) begin
      o.value = a;
      o.code  = bcd_as_pkg::ST_BAD_DIGIT;
      return o;
    end
    // digit serial carry or borrow chain
    for (i = 0; i < n; i++) begin
      da = a[4*i +: 4];
      db = b[4*i +: 4];
      if (!cmd) begin
        d     = da + db + carry;
        carry = (d >= 10);
        if (carry) d -= 10;
      end else begin
        if (da < db + carry) begin
          d     = da + 10 - db - carry;
          carry = 1'b1;
        end else begin
          d     = da - db - carry;
          carry = 1'b0;
        end
      end
      low[4*i +: 4] = d[3:0];
    end
    if (carry) begin
      o.value = a;
      o.code  = bcd_as_pkg::ST_OVERFLOW;
      return o;
    end
    keep    = (n >= 16) ? '0 : ~((64'd1 << (4*n)) - 64'd1);
    o.value = (a & keep) | low;
    o.code  = bcd_as_pkg::ST_OK;
    return o;
  endfunction

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // drive one operation with random sender gaps, predict on acceptance
  task automatic send_op(input logic cmd, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] b);
    bcd_outcome_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start     = 1'b1;
    command   = cmd;
    operand_a = a;
    operand_b = b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    want = predict_bcd(cmd, a, b, digits_cfg);
    pending_sums.push_back(want);
    n_ops++;
    case (want.code)
      bcd_as_pkg::ST_OK:        n_ok++;
      bcd_as_pkg::ST_BAD_DIGIT: n_bad++;
      default:                  n_ovf++;
    endcase
    @(negedge clk);
  endtask

  // hold off until every outstanding result is back
  task automatic wait_drained();
    start = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // digit count write, only with the chain empty
  task automatic write_digits(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_data  = value;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    digits_cfg = value;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random operand, valid bcd in the used digits, anything above
  function automatic logic [DATA_W-1:0] rand_operand(input int n, input bit extremes);
    logic [DATA_W-1:0] v;
    int                i;
    v = {$urandom, $urandom};
    for (i = 0; i < n; i++) begin
      if (extremes) v[4*i +: 4] = $urandom_range(0, 1) ? 4'd9 : 4'd0;
      else          v[4*i +: 4] = 4'($urandom_range(0, 9));
    end
    return v;
  endfunction

  // digit counts weighted toward the extremes
  function automatic logic [CNT_W-1:0] pick_digits();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'd31;
      3:       return 5'd1;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // mostly well formed operands, some bad digits and raw noise
  task automatic send_random_op();
    int                n;
    int                kind;
    int                p;
    logic              cmd;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] t;
    bit                extremes;
    n    = used_digits(digits_cfg);
    kind = $urandom_range(0, 99);
    cmd  = 1'($urandom_range(0, 1));
    if (kind < 15) begin
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
    end else begin
      extremes = ($urandom_range(0, 4) == 0);
      a = rand_operand(n, extremes);
      b = rand_operand(n, extremes);
      m = (n >= 16) ? '1 : ((64'd1 << (4*n)) - 64'd1);
      // swap the operands of about half the subtractions that would end in a borrow
      if (cmd && $urandom_range(0, 1) && ((a & m) < (b & m))) begin
        t = a;
        a = b;
        b = t;
      end
      if (kind < 30 && n > 0) begin
        p = $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) a[4*p +: 4] = 4'($urandom_range(10, 15));
        else                      b[4*p +: 4] = 4'($urandom_range(10, 15));
      end
    end
    send_op(cmd, a, b);
  endtask

  // reset digit count, full width corner cases
  task automatic test_full_width();
    send_op(1'b0, 64'h0, 64'h0);
    send_op(1'b0, 64'h9999999999999999, 64'h1);
    send_op(1'b0, 64'h9999999999999999, 64'h0);
    send_op(1'b0, 64'h0999999999999999, 64'h1);
    send_op(1'b0, 64'h12345678, 64'h87654321);
    send_op(1'b1, 64'h0, 64'h1);
    send_op(1'b1, 64'h9999999999999999, 64'h9999999999999999);
    send_op(1'b1, 64'h5, 64'h3);
    send_op(1'b1, 64'hA, 64'h0);
    send_op(1'b0, 64'h1, 64'hF000000000000000);
    send_op(1'b0, 64'h9999999999999999, 64'hA999999999999999);
    send_op(1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
  endtask

  // no digits in use, everything passes through as ok
  task automatic test_no_digits();
    write_digits(5'd0);
    send_op(1'b0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
    send_op(1'b1, 64'h0, 64'h1);
  endtask

  // single digit, upper nibbles ignored or passed through
  task automatic test_one_digit();
    write_digits(5'd1);
    send_op(1'b0, 64'hFFFFFFFFFFFFFFF5, 64'h4);
    send_op(1'b0, 64'h5, 64'h5);
    send_op(1'b1, 64'h3, 64'h4);
    send_op(1'b1, 64'h7, 64'hFFFFFFFFFFFFFFF2);
  endtask

  // counts above the digit width saturate
  task automatic test_digit_saturation();
    write_digits(5'd31);
    send_op(1'b0, 64'h9999999999999999, 64'h1);
    send_op(1'b0, 64'h8888888888888888, 64'h1111111111111111);
    write_digits(5'd17);
    send_op(1'b1, 64'h1000000000000000, 64'h1);
  endtask

  // random operations over several digit counts, with one full pause
  task automatic test_random_phase();
    int seg;
    int k;
    for (seg = 0; seg < 4; seg++) begin
      write_digits(pick_digits());
      for (k = 0; k < 80; k++) begin
        if (seg == 1 && k == 40) wait_drained();
        send_random_op();
      end
    end
  endtask

  // compare each result with the oldest outstanding expectation
  always @(posedge clk) begin : check_results
    bcd_outcome_t want;
    if (!rst && done) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result %h status %0d with nothing outstanding",
                                  result, status));
      end else begin
        want = pending_sums.pop_front();
        if (result !== want.value)
          report_mismatch($sformatf("cmd %0d a %h b %h: result %h, want %h",
                                    want.cmd, want.a, want.b, result, want.value));
        if (status !== want.code)
          report_mismatch($sformatf("cmd %0d a %h b %h: status %0d, want %0d",
                                    want.cmd, want.a, want.b, status, want.code));
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb_bcd_add_subtract_top: done, errors");
    $finish;
  end

  // test sequence
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    command     = 1'b0;
    operand_a   = '0;
    operand_b   = '0;
    cfg_valid   = 1'b0;
    cfg_data    = DIGITS_RESET;
    digits_cfg  = DIGITS_RESET;
    idle_pct    = 33;
    error_count = 0;
    n_ops       = 0;
    n_ok        = 0;
    n_bad       = 0;
    n_ovf       = 0;
    n_cfg       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_full_width();
    test_no_digits();
    test_one_digit();
    test_digit_saturation();
    idle_pct = 33;
    test_random_phase();
    idle_pct = 53;
    test_random_phase();
    idle_pct = 0;
    test_random_phase();

    // drain and watch for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_sums.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));

    $display("covered %0d operations: %0d ok, %0d bad digit, %0d overflow/underflow",
             n_ops, n_ok, n_bad, n_ovf);
    $display("digit count written %0d times, sender gaps 33%%, 53%%, then back to back",
             n_cfg);
    if (error_count == 0) $display("tb_bcd_add_subtract_top: done, clean");
    else $display("tb_bcd_add_subtract_top: done, errors");
    $finish;
  end

endmodule
